>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the execute unit
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every edge outside reset
`define C8X_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property checked on every edge, reset included
`define C8X_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/core/c8x_pkg.sv
// ----------------------------------------------------------------------------
// c8x_pkg
// constants, opcode codes and the execute result type of the execute unit
// ----------------------------------------------------------------------------
`default_nettype none

package c8x_pkg;

  localparam int ADDR_BITS   = 12;
  localparam int STACK_DEPTH = 16;
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int SP_IDX_W    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int RET_W       = 12;
  localparam int NEXT_PC_W   = 12;
  localparam int DEPTH_OUT_W = 5;
  localparam int NUM_REGS    = 16;

  localparam logic [ADDR_BITS-1:0] PC_RESET = ADDR_BITS'(16'h0200);
  localparam logic [3:0]           REG_F    = 4'hF;

  // top nibble of the instruction word
  typedef enum logic [3:0] {
    OP_JP     = 4'h1,
    OP_CALL   = 4'h2,
    OP_SE_KK  = 4'h3,
    OP_SNE_KK = 4'h4,
    OP_SE_XY  = 4'h5,
    OP_LD_KK  = 4'h6,
    OP_ADD_KK = 4'h7,
    OP_ALU    = 4'h8
  } op_class_t;

  // low nibble of an 8XYn word
  typedef enum logic [3:0] {
    FN_LD  = 4'h0,
    FN_OR  = 4'h1,
    FN_AND = 4'h2,
    FN_XOR = 4'h3,
    FN_ADD = 4'h4,
    FN_SUB = 4'h5
  } alu_fn_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] next_pc;
    logic                 reg_written;
    logic [3:0]           dest_index;
    logic [7:0]           dest_value;
    logic [7:0]           flag_value;
    logic                 unsupported;
    logic                 stack_overflow;
    logic [SP_W-1:0]      stack_depth;
    logic                 push_en;
    logic [RET_W-1:0]     push_addr;
  } exec_t;

endpackage

`default_nettype wire

>>> rtl/core/chip8_execute_unit.sv
// ----------------------------------------------------------------------------
// chip8_execute_unit
// One instruction word per cycle while the result is not stalled: a word taken at one edge
// sits in the input register with its VX and VY operands, is executed once the result
// register can take it and lands there. The register file read port is registered at
// acceptance and bypasses the write of the instruction executing in that same cycle, so
// back-to-back dependent words need no stall. The input stalls only while both the input
// register and the result register are full and the result is stalled.
// Reset puts pc at 0x200, empties the return stack and clears V0..VF at once.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module chip8_execute_unit
  import c8x_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [15:0]            in_instruction,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [NEXT_PC_W-1:0]        out_next_pc,
  output logic                        out_reg_written,
  output logic [3:0]                  out_dest_index,
  output logic [7:0]                  out_dest_value,
  output logic [7:0]                  out_flag_value,
  output logic                        out_unsupported,
  output logic                        out_stack_overflow,
  output logic [DEPTH_OUT_W-1:0]      out_stack_depth
);

  // ---------------------------------------------------------------- state
  logic                 s1_valid_r;
  logic [15:0]          s1_instr_r;
  logic [7:0]           s1_vx_r;
  logic [7:0]           s1_vy_r;
  logic [ADDR_BITS-1:0] pc_r;
  logic [SP_W-1:0]      sp_r;
  logic [7:0]           vf_r;
  logic [NUM_REGS-1:0]  rf_vld_r;
  logic [7:0]           rf_mem [NUM_REGS];
  // return addresses pushed by a call
  logic [RET_W-1:0]     ret_mem [STACK_DEPTH];

  logic                 out_valid_r;
  logic [NEXT_PC_W-1:0] out_next_pc_r;
  logic                 out_reg_written_r;
  logic [3:0]           out_dest_index_r;
  logic [7:0]           out_dest_value_r;
  logic [7:0]           out_flag_value_r;
  logic                 out_unsupported_r;
  logic                 out_stack_overflow_r;
  logic [DEPTH_OUT_W-1:0] out_stack_depth_r;

  // ---------------------------------------------------------------- control
  logic       exec_go;
  logic       in_accept;
  logic       rf_we;
  logic [7:0] vf_nxt;
  logic [3:0] in_x;
  logic [3:0] in_y;
  exec_t      ex;

  assign exec_go   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !exec_go;
  assign in_accept = in_valid && !in_stall;
  assign in_x      = in_instruction[11:8];
  assign in_y      = in_instruction[7:4];

  c8x_exec u_exec (
    .instr (s1_instr_r),
    .vx    (s1_vx_r),
    .vy    (s1_vy_r),
    .vf    (vf_r),
    .pc    (pc_r),
    .sp    (sp_r),
    .res   (ex)
  );

  // VF lives outside the array so flag and destination can both land in the same cycle
  assign rf_we  = exec_go && ex.reg_written && (ex.dest_index != REG_F);
  assign vf_nxt = exec_go ? ex.flag_value : vf_r;

  // ---------------------------------------------------------------- control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pc_r        <= PC_RESET;
      sp_r        <= '0;
      vf_r        <= 8'd0;
      rf_vld_r    <= '0;
    end else begin
      if (in_accept) begin
        s1_valid_r <= 1'b1;
      end else if (exec_go) begin
        s1_valid_r <= 1'b0;
      end
      if (exec_go) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (exec_go) begin
        pc_r <= ex.next_pc;
        sp_r <= ex.stack_depth;
        vf_r <= ex.flag_value;
      end
      if (rf_we) rf_vld_r[ex.dest_index] <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- register file
  always_ff @(posedge clk) begin
    if (rf_we) rf_mem[ex.dest_index] <= ex.dest_value;
  end

  always_ff @(posedge clk) begin
    if (exec_go && ex.push_en) ret_mem[sp_r[SP_IDX_W-1:0]] <= ex.push_addr;
  end

  // operand read with bypass from the word executing this cycle
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_instr_r <= in_instruction;
      if (in_x == REG_F) begin
        s1_vx_r <= vf_nxt;
      end else if (rf_we && (ex.dest_index == in_x)) begin
        s1_vx_r <= ex.dest_value;
      end else if (rf_vld_r[in_x]) begin
        s1_vx_r <= rf_mem[in_x];
      end else begin
        s1_vx_r <= 8'd0;
      end
      if (in_y == REG_F) begin
        s1_vy_r <= vf_nxt;
      end else if (rf_we && (ex.dest_index == in_y)) begin
        s1_vy_r <= ex.dest_value;
      end else if (rf_vld_r[in_y]) begin
        s1_vy_r <= rf_mem[in_y];
      end else begin
        s1_vy_r <= 8'd0;
      end
    end
  end

  // ---------------------------------------------------------------- result register
  always_ff @(posedge clk) begin
    if (exec_go) begin
      out_next_pc_r        <= ex.next_pc[NEXT_PC_W-1:0];
      out_reg_written_r    <= ex.reg_written;
      out_dest_index_r     <= ex.dest_index;
      out_dest_value_r     <= ex.dest_value;
      out_flag_value_r     <= ex.flag_value;
      out_unsupported_r    <= ex.unsupported;
      out_stack_overflow_r <= ex.stack_overflow;
      out_stack_depth_r    <= DEPTH_OUT_W'(ex.stack_depth);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_next_pc        = out_next_pc_r;
  assign out_reg_written    = out_reg_written_r;
  assign out_dest_index     = out_dest_index_r;
  assign out_dest_value     = out_dest_value_r;
  assign out_flag_value     = out_flag_value_r;
  assign out_unsupported    = out_unsupported_r;
  assign out_stack_overflow = out_stack_overflow_r;
  assign out_stack_depth    = out_stack_depth_r;

  // ---------------------------------------------------------------- assertions
  `C8X_ASSERT(a_sp_bound, clk, rst_n, sp_r <= SP_W'(STACK_DEPTH), "stack count past depth")
  `C8X_ASSERT(a_ovf_full, clk, rst_n,
    out_valid_r && out_stack_overflow_r |-> out_stack_depth_r == DEPTH_OUT_W'(STACK_DEPTH),
    "overflow with stack not full")
  `C8X_ASSERT(a_unsup_nowr, clk, rst_n,
    out_valid_r && out_unsupported_r |-> !out_reg_written_r,
    "unsupported word wrote a register")
  `C8X_ASSERT(a_out_src, clk, rst_n, $rose(out_valid_r) |-> $past(s1_valid_r),
    "result word without a pending instruction")

endmodule

`default_nettype wire

>>> rtl/core/c8x_exec.sv
// ----------------------------------------------------------------------------
// c8x_exec
// combinational execute of one instruction against the current machine state
// ----------------------------------------------------------------------------
`default_nettype none

module c8x_exec
  import c8x_pkg::*;
(
  input  wire logic [15:0]          instr,
  input  wire logic [7:0]           vx,
  input  wire logic [7:0]           vy,
  input  wire logic [7:0]           vf,
  input  wire logic [ADDR_BITS-1:0] pc,
  input  wire logic [SP_W-1:0]      sp,
  output exec_t                     res
);

  op_class_t            cls;
  logic [3:0]           x;
  logic [3:0]           y;
  logic [3:0]           n;
  logic [7:0]           kk;
  logic [ADDR_BITS-1:0] target;
  logic [ADDR_BITS-1:0] pc_inc;
  logic [ADDR_BITS-1:0] pc_skip;
  logic [8:0]           sum;
  logic                 gt;
  logic [7:0]           vx_u;
  logic [7:0]           vy_u;
  logic                 written;
  logic [7:0]           val;

  always_comb begin
    cls     = op_class_t'(instr[15:12]);
    x       = instr[11:8];
    y       = instr[7:4];
    n       = instr[3:0];
    kk      = instr[7:0];
    target  = ADDR_BITS'(instr[11:0]);
    pc_inc  = pc + ADDR_BITS'(2);
    pc_skip = pc + ADDR_BITS'(4);
    sum     = {1'b0, vx} + {1'b0, vy};
    gt      = (vx > vy);
    // subtract sees VF already holding the compare result
    vx_u    = (x == REG_F) ? {7'd0, gt} : vx;
    vy_u    = (y == REG_F) ? {7'd0, gt} : vy;

    written            = 1'b0;
    val                = 8'd0;
    res                = '0;
    res.next_pc        = pc_inc;
    res.flag_value     = vf;
    res.stack_depth    = sp;
    res.push_addr      = RET_W'(pc_inc);

    unique case (cls)
      OP_JP: begin
        res.next_pc = target;
      end
      OP_CALL: begin
        res.next_pc = target;
        if (sp < SP_W'(STACK_DEPTH)) begin
          res.push_en     = 1'b1;
          res.stack_depth = sp + SP_W'(1);
        end else begin
          res.stack_overflow = 1'b1;
        end
      end
      OP_SE_KK: begin
        if (vx == kk) res.next_pc = pc_skip;
      end
      OP_SNE_KK: begin
        if (vx != kk) res.next_pc = pc_skip;
      end
      OP_SE_XY: begin
        if (n != 4'h0) begin
          res.unsupported = 1'b1;
        end else if (vx == vy) begin
          res.next_pc = pc_skip;
        end
      end
      OP_LD_KK: begin
        written = 1'b1;
        val     = kk;
      end
      OP_ADD_KK: begin
        written = 1'b1;
        val     = vx + kk;
      end
      OP_ALU: begin
        written = 1'b1;
        unique case (alu_fn_t'(n))
          FN_LD:  val = vy;
          FN_OR:  val = vx | vy;
          FN_AND: val = vx & vy;
          FN_XOR: val = vx ^ vy;
          FN_ADD: begin
            res.flag_value = {7'd0, sum[8]};
            val            = sum[7:0];
          end
          FN_SUB: begin
            res.flag_value = {7'd0, gt};
            val            = vx_u - vy_u;
          end
          default: begin
            written         = 1'b0;
            res.unsupported = 1'b1;
          end
        endcase
      end
      default: begin
        res.unsupported = 1'b1;
      end
    endcase

    res.reg_written = written;
    res.dest_index  = written ? x : 4'd0;
    res.dest_value  = written ? val : 8'd0;
    // a write to VF overrides the flag
    if (written && (x == REG_F)) res.flag_value = val;
  end

endmodule

`default_nettype wire

>>> test/chip8_execute_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chip8_execute_unit_tb
// Sends CHIP-8 instruction words through the execute unit, with random gaps on
// the input side and random stalls on the result side. A scoreboard keeps its
// own copy of V0..VF, pc and the call stack depth, predicts every result word
// and checks each one against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module chip8_execute_unit_tb;
  import c8x_pkg::*;

  typedef struct packed {
    logic [NEXT_PC_W-1:0]   next_pc;
    logic                   reg_written;
    logic [3:0]             dest_index;
    logic [7:0]             dest_value;
    logic [7:0]             flag_value;
    logic                   unsupported;
    logic                   stack_overflow;
    logic [DEPTH_OUT_W-1:0] stack_depth;
  } exec_word_t;

  class exec_scoreboard;
    bit [7:0]           vreg [NUM_REGS];
    bit [ADDR_BITS-1:0] pc;
    int unsigned        depth;
    exec_word_t         due_q [$];
    int unsigned        mismatches;

    function new();
      foreach (vreg[i]) vreg[i] = '0;
      pc = PC_RESET;
      depth = 0;
      mismatches = 0;
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    function string show(exec_word_t w);
      return $sformatf("pc=%h wr=%b x=%h v=%h vf=%h unsup=%b ovf=%b depth=%0d",
                       w.next_pc, w.reg_written, w.dest_index, w.dest_value,
                       w.flag_value, w.unsupported, w.stack_overflow, w.stack_depth);
    endfunction

    // execute one accepted word against the shadow state
    function void note_word(logic [15:0] w);
      logic [3:0] x;
      logic [3:0] y;
      logic [3:0] n;
      logic [7:0] kk;
      logic [8:0] sum;
      logic       wr;
      logic       unsup;
      logic       ovf;
      exec_word_t r;
      x = w[11:8];
      y = w[7:4];
      n = w[3:0];
      kk = w[7:0];
      wr = 1'b0;
      unsup = 1'b0;
      ovf = 1'b0;
      pc = pc + ADDR_BITS'(2);
      case (w[15:12])
        OP_JP: pc = ADDR_BITS'(w[11:0]);
        OP_CALL: begin
          // full stack: push dropped, jump still taken
          if (depth < STACK_DEPTH) depth++;
          else ovf = 1'b1;
          pc = ADDR_BITS'(w[11:0]);
        end
        OP_SE_KK:  if (vreg[x] == kk) pc = pc + ADDR_BITS'(2);
        OP_SNE_KK: if (vreg[x] != kk) pc = pc + ADDR_BITS'(2);
        OP_SE_XY: begin
          if (n != '0) unsup = 1'b1;
          else if (vreg[x] == vreg[y]) pc = pc + ADDR_BITS'(2);
        end
        OP_LD_KK: begin
          vreg[x] = kk;
          wr = 1'b1;
        end
        OP_ADD_KK: begin
          vreg[x] = vreg[x] + kk;
          wr = 1'b1;
        end
        OP_ALU: begin
          wr = 1'b1;
          case (n)
            FN_LD:  vreg[x] = vreg[y];
            FN_OR:  vreg[x] = vreg[x] | vreg[y];
            FN_AND: vreg[x] = vreg[x] & vreg[y];
            FN_XOR: vreg[x] = vreg[x] ^ vreg[y];
            FN_ADD: begin
              // carry lands in VF first, sum overwrites it when x is F
              sum = {1'b0, vreg[x]} + {1'b0, vreg[y]};
              vreg[REG_F] = {7'd0, sum[8]};
              vreg[x] = sum[7:0];
            end
            FN_SUB: begin
              // difference is taken after VF has been updated
              vreg[REG_F] = (vreg[x] > vreg[y]) ? 8'd1 : 8'd0;
              vreg[x] = vreg[x] - vreg[y];
            end
            default: begin
              wr = 1'b0;
              unsup = 1'b1;
            end
          endcase
        end
        default: unsup = 1'b1;
      endcase
      r.next_pc = NEXT_PC_W'(pc);
      r.reg_written = wr;
      r.dest_index = wr ? x : 4'd0;
      r.dest_value = wr ? vreg[x] : 8'd0;
      r.flag_value = vreg[REG_F];
      r.unsupported = unsup;
      r.stack_overflow = ovf;
      r.stack_depth = DEPTH_OUT_W'(depth);
      due_q.push_back(r);
    endfunction

    function void check_result(exec_word_t got);
      exec_word_t want;
      if (due_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word: %s", show(got));
        return;
      end
      want = due_q.pop_front();
      if (got.next_pc !== want.next_pc || got.reg_written !== want.reg_written ||
          got.dest_index !== want.dest_index || got.dest_value !== want.dest_value ||
          got.flag_value !== want.flag_value || got.unsupported !== want.unsupported ||
          got.stack_overflow !== want.stack_overflow ||
          got.stack_depth !== want.stack_depth) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch at %0t", $time);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [15:0]            in_instruction = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [NEXT_PC_W-1:0]   out_next_pc;
  logic                   out_reg_written;
  logic [3:0]             out_dest_index;
  logic [7:0]             out_dest_value;
  logic [7:0]             out_flag_value;
  logic                   out_unsupported;
  logic                   out_stack_overflow;
  logic [DEPTH_OUT_W-1:0] out_stack_depth;

  exec_scoreboard sb;
  exec_word_t     seen;
  bit             calm = 1'b0;
  int             stall_run = 0;
  bit             stall_on = 1'b0;

  chip8_execute_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_instruction     (in_instruction),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_next_pc        (out_next_pc),
    .out_reg_written    (out_reg_written),
    .out_dest_index     (out_dest_index),
    .out_dest_value     (out_dest_value),
    .out_flag_value     (out_flag_value),
    .out_unsupported    (out_unsupported),
    .out_stack_overflow (out_stack_overflow),
    .out_stack_depth    (out_stack_depth)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #6_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // result side: take words and stall in runs, mostly short
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen.next_pc = out_next_pc;
      seen.reg_written = out_reg_written;
      seen.dest_index = out_dest_index;
      seen.dest_value = out_dest_value;
      seen.flag_value = out_flag_value;
      seen.unsupported = out_unsupported;
      seen.stack_overflow = out_stack_overflow;
      seen.stack_depth = out_stack_depth;
      sb.check_result(seen);
    end
    if (stall_run == 0) begin
      stall_on = !calm && ($urandom_range(0, 2) == 0);
      if (stall_on)
        stall_run = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
      else
        stall_run = $urandom_range(1, 12);
    end
    stall_run--;
    out_stall <= stall_on;
  end

  function automatic int gap_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 9);
    if (r < 6) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_word(input logic [15:0] w);
    in_valid <= 1'b1;
    in_instruction <= w;
    do @(posedge clk); while (in_stall);
    sb.note_word(w);
  endtask

  task automatic idle_gap(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // hold the input until every predicted word has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_word();
    int         r;
    logic [3:0] x;
    logic [3:0] y;
    logic [7:0] kk;
    r = $urandom_range(0, 99);
    // VF as operand often, it carries most of the corner cases
    x = ($urandom_range(0, 3) == 0) ? REG_F : 4'($urandom_range(0, 15));
    y = ($urandom_range(0, 3) == 0) ? REG_F : 4'($urandom_range(0, 15));
    kk = 8'($urandom);
    if (r < 8) return 16'($urandom);
    if (r < 12) return {4'($urandom_range(9, 15)), 12'($urandom)};
    // class 0 has no decode at all
    if (r < 13) return {4'h0, 12'($urandom)};
    if (r < 15) return {OP_SE_XY, x, y, 4'($urandom_range(1, 15))};
    if (r < 17) return {OP_ALU, x, y, 4'($urandom_range(6, 15))};
    case ($urandom_range(0, 7))
      0: return {OP_JP, 12'($urandom)};
      1: return {OP_CALL, 12'($urandom)};
      2: return {OP_SE_KK, x, $urandom_range(0, 1) ? sb.vreg[x] : kk};
      3: return {OP_SNE_KK, x, $urandom_range(0, 1) ? sb.vreg[x] : kk};
      4: return {OP_SE_XY, x, $urandom_range(0, 2) ? y : x, 4'h0};
      5: return {OP_LD_KK, x, kk};
      6: return {OP_ADD_KK, x, kk};
      default: return {OP_ALU, x, y, 4'($urandom_range(0, 5))};
    endcase
  endfunction

  initial begin
    logic [15:0] directed [$];
    sb = new();
    directed = '{
      16'h60FF, 16'h6101, 16'h8014,            // add with carry out
      16'h6F80, 16'h6E90, 16'h8FE4,            // add into VF, sum beats carry
      16'h6230, 16'h6310, 16'h8235,            // subtract, x above y
      16'h8015,                                // subtract with borrow
      16'h8F25, 16'h82F5,                      // subtract with VF as operand
      16'h8120, 16'h8121, 16'h8122, 16'h8123,
      16'h70FF,                                // add immediate wraps
      16'h1FFE, 16'h40FE,                      // jump to top, skip not taken, pc wraps
      16'h5000, 16'h5011, 16'h8016, 16'h801F,  // equal skip, malformed forms
      16'h0000, 16'hA123, 16'hFFFF,
      16'h2FFF, 16'h2000
    };
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed[i]) begin
      send_word(directed[i]);
      idle_gap(gap_len());
    end
    drain();
    for (int seg = 0; seg < 4; seg++) begin
      calm = (seg == 1);
      for (int k = 0; k < 400; k++) begin
        send_word(pick_word());
        idle_gap(gap_len());
        if (seg == 2 && k == 200) drain();
      end
    end
    calm = 1'b0;
    drain();
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> chip8_execute_unit.f
+incdir+rtl/core
rtl/core/c8x_pkg.sv
rtl/core/c8x_exec.sv
rtl/core/chip8_execute_unit.sv
test/chip8_execute_unit_tb.sv
